// ===== rtl/awmt_pkg.sv =====
// Package for the append window max tree: sizes, widths and mode codes.
// No dependencies; used by append_window_max_tree and its testbench.
`default_nettype none
package awmt_pkg;
   localparam int Capacity   = 65536;
   localparam int IdxWidth   = $clog2(Capacity);
   localparam int AddrWidth  = IdxWidth + 1;
   localparam int RangeWidth = AddrWidth + 1;
   localparam int CntWidth   = IdxWidth + 1;
   localparam int DataWidth  = 32;
   localparam int WinWidth   = 17;
   localparam logic ModeAppend = 1'b0;
   localparam logic ModeQuery  = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/awmt_divider.sv =====
// Iterative 33-bit by 33-bit remainder unit, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module awmt_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [32:0] dividend,
   input  wire logic [32:0] divisor,
   output logic             done,
   output logic [31:0]      remainder
);
   logic [32:0] num_ff, num_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [33:0] shifted;

   // Restoring division step: shift in one dividend bit, subtract if it fits.
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff[32:0], num_ff[32]};
      if (start) begin
         num_in = dividend;
         div_in = divisor;
         rem_in = '0;
         cnt_in = 6'd33;
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[31:0], 1'b0};
         if (shifted >= {1'b0, div_ff}) rem_in = shifted - {1'b0, div_ff};
         else rem_in = shifted;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[31:0];
endmodule
`default_nettype wire

// ===== rtl/append_window_max_tree.sv =====
// Top level of the append window max tree: sequencer, tree memory, registers.
// Depends on awmt_pkg and awmt_divider.
//
// Keeps a max segment tree over an append-only list. start with busy low takes
// one transaction. An append runs a 33-step remainder, then writes the leaf
// and walks 16 levels upward with one read and one write per level (states
// StAUp, StARd0 and StAWr). A query walks at most 17 levels, passing through
// StQStep and up to StQRd and StQRdR at each level, and then runs the
// remainder; its result appears in the cycle in which busy drops. A zero or
// empty window answers in the cycle after the transaction without raising
// busy, and an append to a full store is dropped without raising busy. The
// single-port tree memory is why each level needs separate read and write steps.
// After reset the block clears the 131072-word memory, one word a cycle,
// holding busy high until the sweep ends. Query results appear for one cycle
// on rsp_valid; the receiver cannot hold them off.
`default_nettype none
module append_window_max_tree (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_mode,
   input  wire logic [31:0] req_value,
   input  wire logic [16:0] req_window,
   output logic             rsp_valid,
   output logic [31:0]      rsp_max_value,
   output logic             rsp_window_clamped,
   input  wire logic        csr_write,
   input  wire logic [31:0] csr_modulus
);
   localparam int AW = awmt_pkg::AddrWidth;
   localparam int LW = awmt_pkg::RangeWidth;
   localparam int CW = awmt_pkg::CntWidth;

   localparam logic [3:0] StClear = 4'd0, StIdle = 4'd1, StAMod = 4'd2,
      StAUp = 4'd3, StARd0 = 4'd4, StARd1 = 4'd5, StAWr = 4'd6,
      StQStep = 4'd7, StQRd = 4'd8, StQAcc = 4'd9, StQMod = 4'd10,
      StQRdR = 4'd12;

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   last_ff, last_in;
   logic [31:0]   mod_ff;
   logic [LW-1:0] l_ff, l_in, r_ff, r_in;
   logic [LW-1:0] r_dec;
   logic [AW-1:0] p_ff, p_in;
   logic [31:0]   acc_ff, acc_in, left_ff, left_in;
   logic          clamp_ff, clamp_in;
   logic          rv_ff, rv_in;
   logic [31:0]   rmax_ff, rmax_in;
   logic          rcl_ff, rcl_in;

   // Tree memory: one port, synchronous read; data arrives in the cycle after the address.
   logic [31:0]   mem [0:(1 << AW) - 1];
   logic [31:0]   rd_ff;
   logic [AW-1:0] m_addr;
   logic          m_we;
   logic [31:0]   m_wd;

   always_ff @(posedge clock) begin
      if (m_we) mem[m_addr] <= m_wd;
      rd_ff <= mem[m_addr];
   end

   // Remainder unit shared by appends and answers; zero modulus means 2^32.
   logic        dv_start, dv_done;
   logic [32:0] dv_num, dv_den;
   logic [31:0] dv_rem;
   awmt_divider u_div (.clock(clock), .reset(reset), .start(dv_start),
      .dividend(dv_num), .divisor(dv_den), .done(dv_done), .remainder(dv_rem));
   assign dv_den = (mod_ff == 32'd0) ? {1'b1, 32'd0} : {1'b0, mod_ff};

   logic [CW-1:0] win_eff;
   logic [31:0]   maxv;
   assign maxv = (rd_ff > acc_ff) ? rd_ff : acc_ff;

   // The right range bound reaches twice the capacity, so it is one bit wider.
   assign r_dec = r_ff - 1'b1;

   always_comb begin
      state_in = state_ff;  clr_in = clr_ff;  count_in = count_ff;
      last_in = last_ff;    l_in = l_ff;      r_in = r_ff;   p_in = p_ff;
      acc_in = acc_ff;      left_in = left_ff; clamp_in = clamp_ff;
      rv_in = 1'b0;         rmax_in = rmax_ff; rcl_in = rcl_ff;
      m_addr = p_ff;  m_we = 1'b0;  m_wd = dv_rem;
      dv_start = 1'b0;  dv_num = {1'b0, req_value} + {1'b0, last_ff};
      win_eff = (req_window > count_ff) ? count_ff : req_window[CW-1:0];
      case (state_ff)
         // Sweep the whole memory to zero after reset.
         StClear: begin
            m_addr = clr_ff;  m_we = 1'b1;  m_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) state_in = StIdle;
         end
         StIdle: begin
            if (start) begin
               if (req_mode == awmt_pkg::ModeAppend) begin
                  if (count_ff != CW'(awmt_pkg::Capacity)) begin
                     dv_start = 1'b1;
                     p_in = AW'(awmt_pkg::Capacity) + count_ff;
                     state_in = StAMod;
                  end
               end else begin
                  clamp_in = (req_window > count_ff);
                  acc_in = '0;
                  if (win_eff == '0) begin
                     rv_in = 1'b1;  rmax_in = '0;
                     rcl_in = (req_window > count_ff);
                  end else begin
                     l_in = LW'(awmt_pkg::Capacity) + {1'b0, count_ff - win_eff};
                     r_in = LW'(awmt_pkg::Capacity) + {1'b0, count_ff};
                     state_in = StQStep;
                  end
               end
            end
         end
         // Write the reduced leaf, then refresh ancestors one level at a time.
         StAMod: begin
            if (dv_done) begin
               m_we = 1'b1;  m_wd = dv_rem;
               acc_in = dv_rem;  count_in = count_ff + 1'b1;
               state_in = StAUp;
            end
         end
         StAUp: begin
            if (p_ff == AW'(1)) state_in = StIdle;
            else begin
               m_addr = p_ff ^ AW'(1);
               state_in = StARd0;
            end
         end
         StARd0: begin
            // Sibling word arrives; combine with the freshly written child.
            left_in = maxv;
            p_in = p_ff >> 1;
            state_in = StAWr;
         end
         StAWr: begin
            m_we = 1'b1;  m_wd = left_ff;  acc_in = left_ff;
            state_in = StAUp;
         end
         StARd1: state_in = StIdle;
         // Bottom-up range walk over [l, r).
         StQStep: begin
            if (l_ff >= r_ff) begin
               dv_start = 1'b1;  dv_num = {1'b0, acc_ff};
               state_in = StQMod;
            end else if (l_ff[0]) begin
               m_addr = l_ff[AW-1:0];  l_in = l_ff + 1'b1;
               state_in = StQRd;
            end else if (r_ff[0]) begin
               m_addr = r_dec[AW-1:0];  r_in = r_dec;
               state_in = StQRdR;
            end else begin
               l_in = l_ff >> 1;  r_in = r_ff >> 1;
            end
         end
         StQRd: begin
            acc_in = maxv;
            if (r_ff[0]) begin
               m_addr = r_dec[AW-1:0];  r_in = r_dec;
               state_in = StQRdR;
            end else begin
               l_in = l_ff >> 1;  r_in = r_ff >> 1;
               state_in = StQStep;
            end
         end
         StQRdR: begin
            acc_in = maxv;
            l_in = l_ff >> 1;  r_in = r_ff >> 1;
            state_in = StQStep;
         end
         StQMod: begin
            if (dv_done) begin
               rv_in = 1'b1;  rmax_in = dv_rem;  rcl_in = clamp_ff;
               last_in = dv_rem;
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      l_ff <= l_in;  r_ff <= r_in;  p_ff <= p_in;
      acc_ff <= acc_in;  left_ff <= left_in;  clamp_ff <= clamp_in;
      rmax_ff <= rmax_in;  rcl_ff <= rcl_in;
      if (reset) begin
         state_ff <= StClear;  clr_ff <= '0;  count_ff <= '0;
         last_ff <= '0;  rv_ff <= 1'b0;  mod_ff <= 32'hFFFF_FFFF;
      end else begin
         state_ff <= state_in;  clr_ff <= clr_in;  count_ff <= count_in;
         last_ff <= last_in;  rv_ff <= rv_in;
         if (csr_write) mod_ff <= csr_modulus;
      end
   end

   assign busy               = (state_ff != StIdle);
   assign rsp_valid          = rv_ff;
   assign rsp_max_value      = rmax_ff;
   assign rsp_window_clamped = rcl_ff;

   // The list never grows past capacity.
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(awmt_pkg::Capacity)) else $error("count overflow");
   // A result only follows a busy cycle or an idle accept.
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> $past(busy) || $past(start)) else $error("stray result");
   // Remainder is below the modulus when it reports.
   a_rem: assert property (@(posedge clock) disable iff (reset)
      dv_done |-> ({1'b0, dv_rem} < dv_den)) else $error("bad remainder");
endmodule
`default_nettype wire

// ===== tb/sv/append_window_max_tree_checker.sv =====
// Checker for the append window max tree: watches the command, result and
// register ports, predicts every query answer and compares it field by field.
// Depends on awmt_pkg.
`timescale 1ns / 100ps
module append_window_max_tree_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        req_mode,
   input  wire logic [31:0] req_value,
   input  wire logic [16:0] req_window,
   input  wire logic        rsp_valid,
   input  wire logic [31:0] rsp_max_value,
   input  wire logic        rsp_window_clamped,
   input  wire logic        csr_write,
   input  wire logic [31:0] csr_modulus,
   output int               error_count,
   output int               answers_pending
);
   typedef struct packed {
      logic [31:0] max_value;
      logic        window_clamped;
   } window_answer_type;

   // Shadow of the stored list; the tree itself only speeds up the search.
   logic [31:0]       stored_values [0:awmt_pkg::Capacity-1];
   int                stored_count;
   logic [31:0]       prior_answer;
   logic [31:0]       modulus_reg;
   window_answer_type expected_answers [$];

   assign answers_pending = expected_answers.size();

   // Reduce a value by the current modulus, where zero stands for 2^32.
   function automatic logic [31:0] reduce_mod(input logic [63:0] x);
      logic [63:0] m;
      m = (modulus_reg == 32'd0) ? 64'h1_0000_0000 : {32'd0, modulus_reg};
      return 32'(x % m);
   endfunction

   // Work out the answer to one query and, for a non-empty window, update the last answer.
   function automatic window_answer_type window_max(input logic [16:0] window);
      window_answer_type a;
      int                w;
      logic [31:0]       m;
      a = '0;
      w = window;
      m = 32'd0;
      if (w > stored_count) begin
         w = stored_count;
         a.window_clamped = 1'b1;
      end
      if (w != 0) begin
         for (int i = stored_count - w; i < stored_count; i++) begin
            if (stored_values[i] > m) m = stored_values[i];
         end
         a.max_value  = reduce_mod({32'd0, m});
         prior_answer = a.max_value;
      end
      return a;
   endfunction

   // Track transactions, register writes and results at each clock edge.
   always @(posedge clock) begin
      window_answer_type got;
      window_answer_type want;
      if (reset) begin
         stored_count = 0;
         prior_answer = 32'd0;
         modulus_reg  = 32'hFFFF_FFFF;
         error_count  = 0;
         expected_answers.delete();
      end else begin
         if (rsp_valid) begin
            got.max_value      = rsp_max_value;
            got.window_clamped = rsp_window_clamped;
            if (expected_answers.size() == 0) begin
               $error("unexpected result transaction: max_value %0d", rsp_max_value);
               error_count++;
            end else begin
               want = expected_answers.pop_front();
               if (got.max_value !== want.max_value) begin
                  $error("max_value: expected %0d, actual %0d",
                         want.max_value, got.max_value);
                  error_count++;
               end
               if (got.window_clamped !== want.window_clamped) begin
                  $error("window_clamped: expected %0d, actual %0d",
                         want.window_clamped, got.window_clamped);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            if (req_mode == awmt_pkg::ModeQuery) begin
               expected_answers.push_back(window_max(req_window));
            end else if (stored_count < awmt_pkg::Capacity) begin
               stored_values[stored_count] =
                  reduce_mod({32'd0, req_value} + {32'd0, prior_answer});
               stored_count++;
            end
         end
         if (csr_write) modulus_reg = csr_modulus;
      end
   end
endmodule

// ===== tb/sv/append_window_max_tree_tb.sv =====
// Testbench top for the append window max tree: clock, reset, stimulus, verdict.
// Depends on awmt_pkg, append_window_max_tree and append_window_max_tree_checker.
`timescale 1ns / 100ps
module append_window_max_tree_tb;
   localparam longint CycleLimit = 64'd2_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = awmt_pkg::ModeAppend;
   logic [31:0] req_value = 32'd0;
   logic [16:0] req_window = 17'd0;
   logic        rsp_valid;
   logic [31:0] rsp_max_value;
   logic        rsp_window_clamped;
   logic        csr_write = 1'b0;
   logic [31:0] csr_modulus = 32'd0;
   int          error_count;
   int          answers_pending;
   int          idle_percent;
   int          appended;
   longint      cycle_count = 0;

   append_window_max_tree DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_value(req_value), .req_window(req_window),
      .rsp_valid(rsp_valid), .rsp_max_value(rsp_max_value),
      .rsp_window_clamped(rsp_window_clamped),
      .csr_write(csr_write), .csr_modulus(csr_modulus)
   );

   append_window_max_tree_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_value(req_value), .req_window(req_window),
      .rsp_valid(rsp_valid), .rsp_max_value(rsp_max_value),
      .rsp_window_clamped(rsp_window_clamped),
      .csr_write(csr_write), .csr_modulus(csr_modulus),
      .error_count(error_count), .answers_pending(answers_pending)
   );

   always #5 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Issue one transaction, with a random gap ahead of it at the current idle rate.
   task automatic send_command(input logic mode, input logic [31:0] value,
                               input logic [16:0] window);
      if ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start      <= 1'b1;
      req_mode   <= mode;
      req_value  <= value;
      req_window <= window;
      do @(posedge clock); while (busy);
      if (mode == awmt_pkg::ModeAppend && appended < awmt_pkg::Capacity) appended++;
   endtask

   // Hold off until every answer has come and the block has gone idle.
   task automatic drain;
      start <= 1'b0;
      do @(posedge clock); while (answers_pending != 0);
      repeat (100) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Write the modulus while the block is idle.
   task automatic write_modulus(input logic [31:0] m);
      drain();
      csr_write   <= 1'b1;
      csr_modulus <= m;
      @(posedge clock);
      csr_write   <= 1'b0;
   endtask

   // One random transaction; windows mostly run from one to just past the stored count.
   task automatic random_command;
      logic [16:0] w;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 5)       w = 17'd0;
      else if (pick < 15) w = 17'($urandom_range(0, awmt_pkg::Capacity));
      else                w = 17'($urandom_range(1, appended + 2));
      if ($urandom_range(99) < 35) send_command(awmt_pkg::ModeQuery, $urandom, w);
      else                         send_command(awmt_pkg::ModeAppend, $urandom, w);
   endtask

   initial begin
      appended     = 0;
      idle_percent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // The block clears its tree memory after reset, with busy high.
      do @(posedge clock); while (busy);

      // Directed: empty store, extreme values, zero and oversized windows.
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd0);
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd5);
      send_command(awmt_pkg::ModeQuery, 32'hFFFF_FFFF, 17'd65536);
      send_command(awmt_pkg::ModeAppend, 32'hFFFF_FFFF, 17'h1FFFF);
      send_command(awmt_pkg::ModeAppend, 32'd0, 17'd0);
      send_command(awmt_pkg::ModeAppend, 32'hFFFF_FFFE, 17'd0);
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd1);
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd3);
      send_command(awmt_pkg::ModeAppend, 32'd7, 17'd0);
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd0);
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd2);
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd65536);
      send_command(awmt_pkg::ModeAppend, 32'h8000_0000, 17'd0);
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd1);

      // Zero modulus means 2^32: sums wrap, answers are not reduced.
      write_modulus(32'd0);
      send_command(awmt_pkg::ModeAppend, 32'hFFFF_FFFF, 17'd0);
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd4);
      idle_percent = 10;
      repeat (600) random_command();

      // Small modulus; stored values are kept as they were.
      write_modulus($urandom_range(2, 1000));
      idle_percent = 54;
      repeat (600) random_command();

      // Modulus of one reduces every answer to zero.
      write_modulus(32'd1);
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd3);
      send_command(awmt_pkg::ModeAppend, 32'd12345, 17'd0);
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd65536);

      write_modulus($urandom | 32'h8000_0000);
      idle_percent = 0;
      repeat (600) random_command();

      // Wide and oversized windows over the whole stored list.
      write_modulus(32'hFFFF_FFFF);
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd65536);
      send_command(awmt_pkg::ModeAppend, 32'hFFFF_FFFF, 17'd0);
      send_command(awmt_pkg::ModeAppend, $urandom, 17'd0);
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd1);
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd65535);
      send_command(awmt_pkg::ModeQuery, 32'd0, 17'd65536);

      drain();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/awmt_pkg.sv
rtl/awmt_divider.sv
rtl/append_window_max_tree.sv
tb/sv/append_window_max_tree_checker.sv
tb/sv/append_window_max_tree_tb.sv
